/* hw/rtl/qrs_pkg.sv */
// shared codes for the quadratic root solver
package qrs_pkg;

  // result class of one coefficient set
  localparam logic [1:0] KIND_AZERO = 2'd0;
  localparam logic [1:0] KIND_NONE  = 2'd1;
  localparam logic [1:0] KIND_ONE   = 2'd2;
  localparam logic [1:0] KIND_TWO   = 2'd3;

  // status field codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_AZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

endpackage

/* hw/rtl/qrs_ifs.sv */
// valid/ready channels for coefficient words and root words
interface qrs_in_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if #(parameter int W = 32) ();
  logic                valid;
  logic                ready;
  logic        [1:0]   root_count;
  logic signed [W-1:0] root_plus;
  logic signed [W-1:0] root_minus;
  logic        [1:0]   status;

  modport source (output valid, root_count, root_plus, root_minus, status, input ready);
  modport sink (input valid, root_count, root_plus, root_minus, status, output ready);
endinterface

/* hw/rtl/quadratic_root_solver_top.sv */
// top level of the fixed-point quadratic root solver
// Accepts one coefficient set (a, b, c) per cycle while the output is not stalled and
// returns one result word per set, in order: register stages for input capture,
// squaring and the discriminant, WORD_BITS+1 square root cells, a register to form
// the numerators, WORD_BITS+FRAC_BITS+2 divider cells per root and the output
// register. Every stage advances together whenever the output register is empty or
// being read, so a stalled output holds the whole pipe and the input is ready again as
// soon as the output word moves. Roots are truncated toward zero and clamped on overflow.
module quadratic_root_solver_top
  import qrs_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  qrs_in_if.sink    in_ch,
  qrs_out_if.source out_ch
);

  localparam int W       = WORD_BITS;
  localparam int SW      = W + 1;
  localparam int DW      = 2 * SW;
  localparam int NW      = W + 2 + FRAC_BITS;
  localparam int DENW    = W + 1;
  localparam int SQ_SIDE = 4 + 2 * W;
  localparam int DV_SIDE = 3;

  logic adv;

  // stage 1: capture
  logic         v1;
  logic [W-1:0] a1, b1, c1;

  // stage 2: magnitudes and products
  logic           v2, az2, an2, bn2, diff2;
  logic [W-1:0]   am2, bm2;
  logic [2*W-1:0] b2_2, ac2;
  logic [W-1:0]   am_c, bm_c, cm_c;

  // stage 3: discriminant
  logic          v3, an3, bn3;
  logic [1:0]    kind3, kind_c;
  logic [W-1:0]  am3, bm3;
  logic [DW-1:0] d3, ac4, b2x, d_c;

  // sqrt chain links
  logic               sq_v    [SW+1];
  logic [SW+1:0]      sq_rem  [SW+1];
  logic [SW-1:0]      sq_root [SW+1];
  logic [DW-1:0]      sq_d    [SW+1];
  logic [SQ_SIDE-1:0] sq_side [SW+1];

  // stage 4: numerators
  logic [1:0]    kind_s;
  logic          an_s, bn_s;
  logic [W-1:0]  am_s, bm_s;
  logic [W+2:0]  sx, bx, bsx, np, nm;
  logic [W+2:0]  np_abs, nm_abs;
  logic          v4, negp4, negm4;
  logic [1:0]    kind4;
  logic [NW-1:0] nump4, numm4;
  logic [DENW-1:0] den4;

  // divider chain links
  logic               dp_v    [NW+1];
  logic [DENW-1:0]    dp_rem  [NW+1];
  logic [NW-1:0]      dp_q    [NW+1];
  logic [NW-1:0]      dp_num  [NW+1];
  logic [DENW-1:0]    dp_den  [NW+1];
  logic [DV_SIDE-1:0] dp_side [NW+1];
  logic               dm_v    [NW+1];
  logic [DENW-1:0]    dm_rem  [NW+1];
  logic [NW-1:0]      dm_q    [NW+1];
  logic [NW-1:0]      dm_num  [NW+1];
  logic [DENW-1:0]    dm_den  [NW+1];
  logic               dm_side [NW+1];

  // output stage
  logic [1:0]    kind_o;
  logic          negp_o, negm_o, satp, satm;
  logic [NW-1:0] limp, limm;
  logic [W-1:0]  valp, valm, rootp, rootm;
  logic          vo;
  logic [1:0]    count_next, status_next;
  logic [W-1:0]  plus_next, minus_next;
  logic [1:0]    count_r, status_r;
  logic [W-1:0]  plus_r, minus_r;

  // whole pipe moves when the output register frees up
  assign adv         = !vo || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= in_ch.coef_a;
      b1 <= in_ch.coef_b;
      c1 <= in_ch.coef_c;
    end
  end

  // stage 2: sign and magnitude, squares
  assign am_c = a1[W-1] ? (~a1 + 1'b1) : a1;
  assign bm_c = b1[W-1] ? (~b1 + 1'b1) : b1;
  assign cm_c = c1[W-1] ? (~c1 + 1'b1) : c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      az2   <= (am_c == '0);
      an2   <= a1[W-1];
      bn2   <= b1[W-1];
      diff2 <= a1[W-1] ^ c1[W-1];
      am2   <= am_c;
      bm2   <= bm_c;
      b2_2  <= bm_c * bm_c;
      ac2   <= am_c * cm_c;
    end
  end

  // stage 3: discriminant and root class
  assign ac4 = {ac2, 2'b00};
  assign b2x = {2'b00, b2_2};
  assign d_c = diff2 ? (b2x + ac4) : (b2x - ac4);

  always_comb begin
    if (az2) begin
      kind_c = KIND_AZERO;
    end else if (!diff2 && (b2x < ac4)) begin
      kind_c = KIND_NONE;
    end else if (d_c == '0) begin
      kind_c = KIND_ONE;
    end else begin
      kind_c = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind3 <= kind_c;
      an3   <= an2;
      bn3   <= bn2;
      am3   <= am2;
      bm3   <= bm2;
      d3    <= d_c;
    end
  end

  // square root chain
  assign sq_v[0]    = v3;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_d[0]    = d3;
  assign sq_side[0] = {kind3, an3, bn3, am3, bm3};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    qrs_sqrt_cell #(.DW(DW), .SW(SW), .SIDE_W(SQ_SIDE)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (sq_v[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_d      (sq_d[i]),
      .in_side   (sq_side[i]),
      .out_valid (sq_v[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_d     (sq_d[i+1]),
      .out_side  (sq_side[i+1])
    );
  end

  // stage 4: numerators +-s - b and their magnitudes
  assign {kind_s, an_s, bn_s, am_s, bm_s} = sq_side[SW];
  assign sx     = {2'b00, sq_root[SW]};
  assign bx     = {3'b000, bm_s};
  assign bsx    = bn_s ? (~bx + 1'b1) : bx;
  assign np     = sx - bsx;
  assign nm     = (~sx + 1'b1) - bsx;
  assign np_abs = np[W+2] ? (~np + 1'b1) : np;
  assign nm_abs = nm[W+2] ? (~nm + 1'b1) : nm;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= sq_v[SW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind4 <= kind_s;
      negp4 <= np[W+2] ^ an_s;
      negm4 <= nm[W+2] ^ an_s;
      nump4 <= {np_abs[W+1:0], {FRAC_BITS{1'b0}}};
      numm4 <= {nm_abs[W+1:0], {FRAC_BITS{1'b0}}};
      den4  <= {am_s, 1'b0};
    end
  end

  // divider chains, one per root
  assign dp_v[0]    = v4;
  assign dp_rem[0]  = '0;
  assign dp_q[0]    = '0;
  assign dp_num[0]  = nump4;
  assign dp_den[0]  = den4;
  assign dp_side[0] = {kind4, negp4};
  assign dm_v[0]    = v4;
  assign dm_rem[0]  = '0;
  assign dm_q[0]    = '0;
  assign dm_num[0]  = numm4;
  assign dm_den[0]  = den4;
  assign dm_side[0] = negm4;

  for (genvar i = 0; i < NW; i++) begin : g_div
    qrs_div_cell #(.NW(NW), .DENW(DENW), .SIDE_W(DV_SIDE)) u_plus (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (dp_v[i]),
      .in_rem    (dp_rem[i]),
      .in_q      (dp_q[i]),
      .in_num    (dp_num[i]),
      .in_den    (dp_den[i]),
      .in_side   (dp_side[i]),
      .out_valid (dp_v[i+1]),
      .out_rem   (dp_rem[i+1]),
      .out_q     (dp_q[i+1]),
      .out_num   (dp_num[i+1]),
      .out_den   (dp_den[i+1]),
      .out_side  (dp_side[i+1])
    );
    qrs_div_cell #(.NW(NW), .DENW(DENW), .SIDE_W(1)) u_minus (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .in_valid  (dm_v[i]),
      .in_rem    (dm_rem[i]),
      .in_q      (dm_q[i]),
      .in_num    (dm_num[i]),
      .in_den    (dm_den[i]),
      .in_side   (dm_side[i]),
      .out_valid (dm_v[i+1]),
      .out_rem   (dm_rem[i+1]),
      .out_q     (dm_q[i+1]),
      .out_num   (dm_num[i+1]),
      .out_den   (dm_den[i+1]),
      .out_side  (dm_side[i+1])
    );
  end

  // clamp quotients and apply signs
  assign {kind_o, negp_o} = dp_side[NW];
  assign negm_o = dm_side[NW];
  assign limp   = {{(NW-W){1'b0}}, negp_o, {(W-1){~negp_o}}};
  assign limm   = {{(NW-W){1'b0}}, negm_o, {(W-1){~negm_o}}};
  assign satp   = dp_q[NW] > limp;
  assign satm   = dm_q[NW] > limm;
  assign valp   = satp ? limp[W-1:0] : dp_q[NW][W-1:0];
  assign valm   = satm ? limm[W-1:0] : dm_q[NW][W-1:0];
  assign rootp  = negp_o ? (~valp + 1'b1) : valp;
  assign rootm  = negm_o ? (~valm + 1'b1) : valm;

  // result word per root class
  always_comb begin
    count_next  = 2'd0;
    plus_next   = '0;
    minus_next  = '0;
    status_next = STATUS_OK;
    unique case (kind_o)
      KIND_AZERO: begin
        status_next = STATUS_AZERO;
      end
      KIND_NONE: begin
        status_next = STATUS_OK;
      end
      KIND_ONE: begin
        count_next  = 2'd1;
        plus_next   = rootp;
        status_next = satp ? STATUS_SAT : STATUS_OK;
      end
      default: begin
        count_next  = 2'd2;
        plus_next   = rootp;
        minus_next  = rootm;
        status_next = (satp || satm) ? STATUS_SAT : STATUS_OK;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (adv) begin
      vo <= dp_v[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      count_r  <= count_next;
      plus_r   <= plus_next;
      minus_r  <= minus_next;
      status_r <= status_next;
    end
  end

  assign out_ch.valid      = vo;
  assign out_ch.root_count = count_r;
  assign out_ch.root_plus  = plus_r;
  assign out_ch.root_minus = minus_r;
  assign out_ch.status     = status_r;

endmodule

/* hw/rtl/qrs_sqrt_cell.sv */
// one radix-2 digit of the pipelined square root
module qrs_sqrt_cell #(
  parameter int DW     = 66,
  parameter int SW     = 33,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [SW+1:0]     in_rem,
  input  logic [SW-1:0]     in_root,
  input  logic [DW-1:0]     in_d,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [SW+1:0]     out_rem,
  output logic [SW-1:0]     out_root,
  output logic [DW-1:0]     out_d,
  output logic [SIDE_W-1:0] out_side
);

  logic [SW+1:0] r2;
  logic [SW+1:0] trial;
  logic          ge;

  // bring down the next two radicand bits and try a one digit
  assign r2    = {in_rem[SW-1:0], in_d[DW-1:DW-2]};
  assign trial = {in_root, 2'b01};
  assign ge    = (r2 >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? (r2 - trial) : r2;
      out_root <= {in_root[SW-2:0], ge};
      out_d    <= {in_d[DW-3:0], 2'b00};
      out_side <= in_side;
    end
  end

endmodule

/* hw/rtl/qrs_div_cell.sv */
// one restoring quotient bit of the pipelined divider
module qrs_div_cell #(
  parameter int NW     = 50,
  parameter int DENW   = 33,
  parameter int SIDE_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DENW-1:0]   in_rem,
  input  logic [NW-1:0]     in_q,
  input  logic [NW-1:0]     in_num,
  input  logic [DENW-1:0]   in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DENW-1:0]   out_rem,
  output logic [NW-1:0]     out_q,
  output logic [NW-1:0]     out_num,
  output logic [DENW-1:0]   out_den,
  output logic [SIDE_W-1:0] out_side
);

  logic [DENW:0] r2;
  logic [DENW:0] diff;
  logic          ge;

  // shift in the next dividend bit and subtract when it fits
  assign r2   = {in_rem, in_num[NW-1]};
  assign diff = r2 - {1'b0, in_den};
  assign ge   = (r2 >= {1'b0, in_den});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= ge ? diff[DENW-1:0] : r2[DENW-1:0];
      out_q    <= {in_q[NW-2:0], ge};
      out_num  <= {in_num[NW-2:0], 1'b0};
      out_den  <= in_den;
      out_side <= in_side;
    end
  end

endmodule

/* hw/rtl/qrs_checker.sv */
// port-level checks on result words of the root solver
module qrs_checker
  import qrs_pkg::*;
#(
  parameter int W = 32
) (
  input logic         clk,
  input logic         rst,
  input logic         o_valid,
  input logic         o_ready,
  input logic [1:0]   o_count,
  input logic [W-1:0] o_plus,
  input logic [W-1:0] o_minus,
  input logic [1:0]   o_status
);

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !o_ready |=> o_valid)
    else $error("result word dropped while stalled");

  // zero leading coefficient gives an empty word
  a_azero: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_status == STATUS_AZERO) |->
      (o_count == 2'd0) && (o_plus == '0) && (o_minus == '0))
    else $error("zero leading coefficient with roots");

  // no roots means zero root fields
  a_none: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_count == 2'd0) |-> (o_plus == '0) && (o_minus == '0))
    else $error("root field set with no roots");

  // second root only when two roots
  a_minus: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_count != 2'd2) |-> (o_minus == '0))
    else $error("second root set without two roots");

  // saturation only reported with a root present
  a_sat: assert property (@(posedge clk) disable iff (rst)
    o_valid && (o_status == STATUS_SAT) |-> (o_count != 2'd0))
    else $error("saturation with no root");

endmodule

bind quadratic_root_solver_top qrs_checker #(.W(WORD_BITS)) u_qrs_checker (
  .clk      (clk),
  .rst      (rst),
  .o_valid  (out_ch.valid),
  .o_ready  (out_ch.ready),
  .o_count  (out_ch.root_count),
  .o_plus   (out_ch.root_plus),
  .o_minus  (out_ch.root_minus),
  .o_status (out_ch.status)
);
